/* rtl/adf_pkg.sv */
package adf_pkg;

  // Frame tail bytes
  localparam logic [7:0] TAIL_FIRST  = 8'h0D;
  localparam logic [7:0] TAIL_SECOND = 8'h0A;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int CORE_LEN_W  = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_MARKER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_ADDRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_ADDRESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_TYPE    = 2'd3;

  typedef struct packed {
    logic [7:0] head_marker;
    logic [7:0] link_address;
    logic [7:0] board_address;
    logic [7:0] board_type;
  } cfg_t;

  // Front to back: payload byte writes and frame outcome
  typedef struct packed {
    logic       en;
    logic [7:0] data;
    logic       commit;
    logic       drop;
  } pay_ctl_t;

endpackage

/* rtl/adf_if.sv */
interface adf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface adf_core_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    core_byte;
  logic [adf_pkg::CORE_LEN_W-1:0] core_length;
  logic                          last;

  modport source (output valid, output core_byte, output core_length, output last,
                  input ready);
  modport sink   (input valid, input core_byte, input core_length, input last,
                  output ready);
endinterface

/* rtl/adf_front.sv */
module adf_front #(
  parameter int MAX_CORE = 32,
  parameter int LW       = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  adf_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  output logic               in_ready,
  output adf_pkg::pay_ctl_t  pay,
  input  logic               buf_full,
  output logic               desc_push,
  output logic [LW-1:0]      desc_len,
  input  logic               desc_full
);

  localparam int LEN_MAX = MAX_CORE + 2;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LINK, PH_LEN, PH_BADDR, PH_BTYPE, PH_DATA, PH_TAIL1, PH_TAIL2
  } phase_t;

  phase_t        phase, phase_next, restart_phase;
  logic [LW-1:0] plen, plen_next;
  logic [LW-1:0] count, count_next;
  logic          accept;
  logic          len_ok;
  logic          data_done;

  assign in_ready  = !buf_full && !desc_full;
  assign accept    = in_valid && in_ready;
  assign desc_len  = plen;
  assign len_ok    = (in_byte >= 8'd2) && ({1'b0, in_byte} <= 9'(LEN_MAX));
  assign data_done = ((LW+1)'(count) + (LW+1)'(1)) == (LW+1)'(plen);
  assign restart_phase = (in_byte == cfg.head_marker) ? PH_LINK : PH_HUNT;

  always_comb begin
    phase_next = phase;
    plen_next  = plen;
    count_next = count;
    pay        = '0;
    desc_push  = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          phase_next = restart_phase;
        end
        PH_LINK: begin
          if (in_byte == cfg.link_address) phase_next = PH_LEN;
          else begin
            phase_next = restart_phase;
            pay.drop   = 1'b1;
          end
        end
        PH_LEN: begin
          if (len_ok) begin
            plen_next  = LW'(in_byte - 8'd2);
            phase_next = PH_BADDR;
          end else begin
            phase_next = restart_phase;
            pay.drop   = 1'b1;
          end
        end
        PH_BADDR: begin
          if (in_byte == cfg.board_address) phase_next = PH_BTYPE;
          else begin
            phase_next = restart_phase;
            pay.drop   = 1'b1;
          end
        end
        PH_BTYPE: begin
          if (in_byte == cfg.board_type) begin
            count_next = '0;
            phase_next = (plen == '0) ? PH_TAIL1 : PH_DATA;
          end else begin
            phase_next = restart_phase;
            pay.drop   = 1'b1;
          end
        end
        PH_DATA: begin
          pay.en   = 1'b1;
          pay.data = in_byte;
          if (data_done) phase_next = PH_TAIL1;
          else count_next = count + LW'(1);
        end
        PH_TAIL1: begin
          if (in_byte == adf_pkg::TAIL_FIRST) phase_next = PH_TAIL2;
          else begin
            phase_next = restart_phase;
            count_next = '0;
            pay.drop   = 1'b1;
          end
        end
        PH_TAIL2: begin
          count_next = '0;
          if (in_byte == adf_pkg::TAIL_SECOND) begin
            phase_next = PH_HUNT;
            pay.commit = 1'b1;
            desc_push  = 1'b1;
          end else begin
            phase_next = restart_phase;
            pay.drop   = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      plen  <= '0;
      count <= '0;
    end else begin
      phase <= phase_next;
      plen  <= plen_next;
      count <= count_next;
    end
  end

endmodule

/* rtl/adf_desc_fifo.sv */
module adf_desc_fifo #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW:0]      wr_ptr, rd_ptr;
  logic [AW:0]      fill;

  assign fill      = wr_ptr - rd_ptr;
  assign full      = fill == (AW+1)'(DEPTH);
  assign not_empty = fill != '0;
  assign head      = entries[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr[AW-1:0]] <= push_data;
  end

  // Pointers run modulo the queue size.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr[AW-1:0] == AW'(DEPTH - 1)) ?
                  {~wr_ptr[AW], {AW{1'b0}}} : wr_ptr + (AW+1)'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr[AW-1:0] == AW'(DEPTH - 1)) ?
                  {~rd_ptr[AW], {AW{1'b0}}} : rd_ptr + (AW+1)'(1);
      end
    end
  end

endmodule

/* rtl/adf_back.sv */
module adf_back #(
  parameter int MAX_CORE = 32,
  parameter int LW       = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  adf_pkg::pay_ctl_t                pay,
  output logic                             buf_full,
  input  logic                             desc_valid,
  input  logic [LW-1:0]                    desc_len,
  output logic                             desc_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic [adf_pkg::CORE_LEN_W-1:0]   out_length,
  output logic                             out_last
);

  localparam int BUF_DEPTH = 2 ** $clog2(2 * MAX_CORE);
  localparam int AW        = $clog2(BUF_DEPTH);

  logic [7:0]    mem [BUF_DEPTH];
  logic [7:0]    rdata;
  logic [AW:0]   wr_spec, wr_commit, rd_ptr;
  logic [LW-1:0] k;
  logic          rd_en;
  logic          empty_frame;
  logic          burst_end;
  logic          zero_byte;

  assign buf_full    = (wr_spec - rd_ptr) == (AW+1)'(BUF_DEPTH);
  assign rd_en       = desc_valid && (!out_valid || out_ready);
  assign empty_frame = desc_len == '0;
  assign burst_end   = empty_frame || ((k + LW'(1)) == desc_len);
  assign desc_pop    = rd_en && burst_end;
  assign out_byte    = zero_byte ? 8'h00 : rdata;

  // Payload ring: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (pay.en) mem[wr_spec[AW-1:0]] <= pay.data;
    if (rd_en && !empty_frame) rdata <= mem[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_spec    <= '0;
      wr_commit  <= '0;
      rd_ptr     <= '0;
      k          <= '0;
      out_valid  <= 1'b0;
      zero_byte  <= 1'b0;
      out_last   <= 1'b0;
      out_length <= '0;
    end else begin
      if (pay.en) wr_spec <= wr_spec + (AW+1)'(1);
      else if (pay.drop) wr_spec <= wr_commit;
      if (pay.commit) wr_commit <= wr_spec;

      if (rd_en) begin
        out_valid  <= 1'b1;
        zero_byte  <= empty_frame;
        out_last   <= burst_end;
        out_length <= adf_pkg::CORE_LEN_W'(desc_len);
        if (!empty_frame) rd_ptr <= rd_ptr + (AW+1)'(1);
        k <= burst_end ? '0 : k + LW'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/addressed_frame_deframer_core.sv */
// Channel   Dir  Payload                              Handshake
// rx        in   rx_byte[7:0]                         valid/ready, beat on both high
// core      out  core_byte[7:0] core_length[5:0] last valid/ready, beat on both high
// cfg_*     in   cfg_idx[1:0] cfg_data[7:0]           write on cfg_we, no wait
//
// One rx beat per cycle while the payload ring and descriptor queue have room.
// A committed frame drains at one core beat per cycle from the ring read port
// while core is ready, once its closing tail byte is taken.
// Reset (rst, synchronous) returns the parser to hunting and empties ring and
// queue; configuration registers reset to zero.
// The parser and the output drain stall on their own: rx stalls only when the
// ring (2*MAX_CORE rounded up to a power of two) or the four-entry queue fills.
module addressed_frame_deframer_core #(
  parameter int MAX_CORE = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [adf_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [adf_pkg::CFG_DATA_W-1:0]    cfg_data,
  adf_rx_if.sink                            rx,
  adf_core_if.source                        core
);

  // Payload length counts 0..MAX_CORE.
  localparam int LW = $clog2(MAX_CORE + 1);

  adf_pkg::cfg_t     cfg;
  adf_pkg::pay_ctl_t pay;
  logic              buf_full;
  logic              desc_push, desc_full, desc_pop, desc_valid;
  logic [LW-1:0]     desc_len_in, desc_len_out;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        adf_pkg::REG_HEAD_MARKER:   cfg.head_marker   <= cfg_data;
        adf_pkg::REG_LINK_ADDRESS:  cfg.link_address  <= cfg_data;
        adf_pkg::REG_BOARD_ADDRESS: cfg.board_address <= cfg_data;
        adf_pkg::REG_BOARD_TYPE:    cfg.board_type    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: frame parser, writes payload bytes speculatively into the ring,
  // then commits or drops them when the frame resolves.
  adf_front #(
    .MAX_CORE(MAX_CORE),
    .LW(LW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(rx.valid),
    .in_byte(rx.rx_byte),
    .in_ready(rx.ready),
    .pay(pay),
    .buf_full(buf_full),
    .desc_push(desc_push),
    .desc_len(desc_len_in),
    .desc_full(desc_full)
  );

  // Queue of committed frame lengths between parser and drain.
  adf_desc_fifo #(
    .WIDTH(LW),
    .DEPTH(4)
  ) u_desc_fifo (
    .clk(clk),
    .rst(rst),
    .push(desc_push),
    .push_data(desc_len_in),
    .full(desc_full),
    .pop(desc_pop),
    .not_empty(desc_valid),
    .head(desc_len_out)
  );

  // Back: payload ring and output register; hold the beat while core stalls.
  adf_back #(
    .MAX_CORE(MAX_CORE),
    .LW(LW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .pay(pay),
    .buf_full(buf_full),
    .desc_valid(desc_valid),
    .desc_len(desc_len_out),
    .desc_pop(desc_pop),
    .out_valid(core.valid),
    .out_ready(core.ready),
    .out_byte(core.core_byte),
    .out_length(core.core_length),
    .out_last(core.last)
  );

endmodule

/* tb/addressed_frame_deframer_core_tb.sv */
module addressed_frame_deframer_core_tb;

  localparam int MAX_CORE = 32;
  // The longest quiet stretch in a good run is the deliberate sink hold-off
  // plus a long source gap and the settle wait; take it several times over.
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_CALM     = 120;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PHASE_ITEMS   = 36;

  typedef struct packed {
    logic [7:0]                     data;
    logic [adf_pkg::CORE_LEN_W-1:0] len;
    logic                           last;
  } core_beat_t;

  typedef enum logic [2:0] {
    P_HUNT, P_LINK, P_LEN, P_BADDR, P_BTYPE, P_DATA, P_TAIL1, P_TAIL2
  } parse_phase_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_TYPED, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [7:0]    rx;
    core_beat_t    beat;
    adf_pkg::cfg_t regs;
  } stim_row_t;

  typedef enum logic [1:0] {FLAW_NONE, FLAW_BYTE, FLAW_LENGTH, FLAW_CUT} flaw_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [adf_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [adf_pkg::CFG_DATA_W-1:0] cfg_data;

  adf_rx_if   rx_if();
  adf_core_if core_if();

  addressed_frame_deframer_core #(.MAX_CORE(MAX_CORE)) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .rx       (rx_if),
    .core     (core_if)
  );

  // Predictor state: a private copy of the parser and its registers
  adf_pkg::cfg_t model_cfg;
  parse_phase_t  ph;
  logic [7:0]    flen;
  logic [5:0]    cnt;
  logic [7:0]    store [MAX_CORE];
  core_beat_t    step_out [MAX_CORE];
  int            step_n;

  // Expected payload beats, oldest first
  core_beat_t payload_due[$];

  // Driver side
  adf_pkg::cfg_t stim_cfg;
  bit            rx_typed;
  core_beat_t    rx_typed_beat;
  int            source_calm;
  int            frame_items;

  int  fail_count;
  int  idle_cycles;
  bit  hold_go;
  bit  long_hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with
  // no gaps at all.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Drop the frame in progress; the same byte may open a new one.
  function automatic void restart(logic [7:0] b);
    ph  = (b == model_cfg.head_marker) ? P_LINK : P_HUNT;
    cnt = '0;
  endfunction

  // Advance the parser by one received byte; fill step_out with the payload
  // beats that the byte releases and return how many there are.
  function automatic int deframe_step(logic [7:0] b);
    int plen;
    int n;
    plen = (flen >= 8'd2) ? int'(flen) - 2 : 0;
    n = 0;
    case (ph)
      P_HUNT: restart(b);
      P_LINK: begin
        if (b == model_cfg.link_address) ph = P_LEN;
        else restart(b);
      end
      P_LEN: begin
        if (b < 8'd2 || int'(b) - 2 > MAX_CORE) begin
          restart(b);
        end else begin
          flen = b;
          ph = P_BADDR;
        end
      end
      P_BADDR: begin
        if (b == model_cfg.board_address) ph = P_BTYPE;
        else restart(b);
      end
      P_BTYPE: begin
        if (b == model_cfg.board_type) begin
          cnt = '0;
          ph = (plen == 0) ? P_TAIL1 : P_DATA;
        end else begin
          restart(b);
        end
      end
      P_DATA: begin
        if (int'(cnt) < MAX_CORE) store[cnt[4:0]] = b;
        if (int'(cnt) + 1 >= plen) ph = P_TAIL1;
        else cnt = cnt + 6'd1;
      end
      P_TAIL1: begin
        if (b == adf_pkg::TAIL_FIRST) ph = P_TAIL2;
        else restart(b);
      end
      default: begin
        if (b == adf_pkg::TAIL_SECOND) begin
          if (plen == 0) begin
            // empty payload still closes with one beat carrying last
            step_out[0] = {8'h00, {adf_pkg::CORE_LEN_W{1'b0}}, 1'b1};
            n = 1;
          end else begin
            for (int k = 0; k < plen && k < MAX_CORE; k++) begin
              step_out[k] = {store[k], plen[adf_pkg::CORE_LEN_W-1:0], (k + 1 == plen)};
              n++;
            end
          end
          ph = P_HUNT;
          cnt = '0;
        end else begin
          restart(b);
        end
      end
    endcase
    return n;
  endfunction

  // Sample both channels and the register port at the rising edge. The
  // rx beat is folded into the predictor before the core beat is checked.
  always @(posedge clk) begin : check_beats
    bit         busy;
    core_beat_t got;
    core_beat_t want;
    busy = 1'b0;
    if (rst) begin
      model_cfg = '0;
      ph = P_HUNT;
      flen = '0;
      cnt = '0;
      idle_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          adf_pkg::REG_HEAD_MARKER:   model_cfg.head_marker   = cfg_data;
          adf_pkg::REG_LINK_ADDRESS:  model_cfg.link_address  = cfg_data;
          adf_pkg::REG_BOARD_ADDRESS: model_cfg.board_address = cfg_data;
          adf_pkg::REG_BOARD_TYPE:    model_cfg.board_type    = cfg_data;
          default: ;
        endcase
      end
      if (rx_if.valid && rx_if.ready) begin
        busy = 1'b1;
        step_n = deframe_step(rx_if.rx_byte);
        // typed rows carry their own expectation in place of the predictor's
        if (rx_typed) begin
          payload_due.push_back(rx_typed_beat);
        end else begin
          for (int k = 0; k < step_n; k++) payload_due.push_back(step_out[k]);
        end
      end
      if (core_if.valid && core_if.ready) begin
        busy = 1'b1;
        got = {core_if.core_byte, core_if.core_length, core_if.last};
        if (payload_due.size() == 0) begin
          note_fail($sformatf("unexpected core beat: byte %02h len %0d last %0b",
                              got.data, got.len, got.last));
        end else begin
          want = payload_due.pop_front();
          if (got.data !== want.data || got.len !== want.len ||
              got.last !== want.last) begin
            note_fail($sformatf({"core beat mismatch: expected byte %02h len %0d ",
                                 "last %0b, got byte %02h len %0d last %0b"},
                                want.data, want.len, want.last,
                                got.data, got.len, got.last));
          end
        end
      end
      if (busy) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Sink: random stalls, plus one long hold-off once the source asks for it
  // so the payload ring and descriptor queue fill and rx backs up.
  initial begin : core_sink
    int gap;
    int sink_calm;
    sink_calm = 0;
    long_hold_done = 1'b0;
    core_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_hold_done && hold_go) begin
        core_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        gap = pick_gap(sink_calm);
        if (gap > 0) begin
          core_if.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      core_if.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Offer one byte at the falling edge and hold it until the rx beat.
  task automatic push_rx(input logic [7:0] b, input bit typed, input core_beat_t beat);
    int gap;
    gap = pick_gap(source_calm);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    rx_typed      = typed;
    rx_typed_beat = beat;
    do @(posedge clk); while (!rx_if.ready);
    @(negedge clk);
  endtask

  // Write all four registers, only once every expected beat is out and the
  // parser has had time to settle.
  task automatic set_registers(input adf_pkg::cfg_t c);
    rx_if.valid <= 1'b0;
    while (payload_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= adf_pkg::REG_HEAD_MARKER;
    cfg_data <= c.head_marker;
    @(negedge clk);
    cfg_idx  <= adf_pkg::REG_LINK_ADDRESS;
    cfg_data <= c.link_address;
    @(negedge clk);
    cfg_idx  <= adf_pkg::REG_BOARD_ADDRESS;
    cfg_data <= c.board_address;
    @(negedge clk);
    cfg_idx  <= adf_pkg::REG_BOARD_TYPE;
    cfg_data <= c.board_type;
    @(negedge clk);
    cfg_we   <= 1'b0;
    stim_cfg = c;
  endtask

  // Build a frame for the current registers, optionally damage it, send it.
  task automatic send_frame(input int plen, input flaw_t flaw);
    logic [7:0] fb[$];
    int pos;
    fb = {stim_cfg.head_marker, stim_cfg.link_address, 8'(plen + 2),
          stim_cfg.board_address, stim_cfg.board_type};
    repeat (plen) fb.push_back(rand_byte());
    fb.push_back(adf_pkg::TAIL_FIRST);
    fb.push_back(adf_pkg::TAIL_SECOND);
    case (flaw)
      FLAW_BYTE: begin
        pos = $urandom_range(0, fb.size() - 1);
        fb[pos] = rand_byte();
      end
      FLAW_LENGTH: begin
        case ($urandom_range(0, 2))
          0:       fb[2] = 8'($urandom_range(0, 1));
          1:       fb[2] = 8'(MAX_CORE + 3);
          default: fb[2] = 8'($urandom_range(MAX_CORE + 3, 255));
        endcase
      end
      FLAW_CUT: begin
        pos = $urandom_range(1, fb.size() - 1);
        fb = fb[0:pos-1];
      end
      default: ;
    endcase
    frame_items += fb.size();
    foreach (fb[i]) push_rx(fb[i], 1'b0, '0);
  endtask

  function automatic stim_row_t b_row(logic [7:0] x);
    return {ROW_BYTE, x, core_beat_t'('0), adf_pkg::cfg_t'('0)};
  endfunction

  function automatic stim_row_t t_row(logic [7:0] x, logic [7:0] d,
                                      logic [adf_pkg::CORE_LEN_W-1:0] l, logic lst);
    return {ROW_TYPED, x, d, l, lst, adf_pkg::cfg_t'('0)};
  endfunction

  function automatic stim_row_t c_row(adf_pkg::cfg_t c);
    return {ROW_CONFIG, 8'h00, core_beat_t'('0), c};
  endfunction

  initial begin : source
    stim_row_t     dir_rows[$];
    adf_pkg::cfg_t c;
    int            plen;
    int            r;
    bit            first;
    flaw_t         flaw;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    rx_typed = 1'b0;
    rx_typed_beat = '0;
    stim_cfg = '0;
    source_calm = 0;
    frame_items = 0;
    fail_count = 0;
    hold_go = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    dir_rows = '{
      // registers still at reset: every matched byte is zero, empty payload
      b_row(8'h00), b_row(8'h00), b_row(8'h02), b_row(8'h00), b_row(8'h00),
      b_row(8'h0D), t_row(8'h0A, 8'h00, 6'd0, 1'b1),
      c_row({8'hFF, 8'h80, 8'h01, 8'h7F}),
      // length byte below two: drop, and the length byte is no new head
      b_row(8'hFF), b_row(8'h80), b_row(8'h01),
      // length one past the largest payload: drop
      b_row(8'hFF), b_row(8'h80), b_row(8'h23),
      // link mismatch on a head marker byte reopens the frame right there
      b_row(8'hFF), b_row(8'hFF), b_row(8'h80), b_row(8'h03), b_row(8'h01),
      b_row(8'h7F), b_row(8'h00), b_row(8'h0D), t_row(8'h0A, 8'h00, 6'd1, 1'b1)
    };

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CONFIG: set_registers(dir_rows[i].regs);
        ROW_TYPED:  push_rx(dir_rows[i].rx, 1'b1, dir_rows[i].beat);
        default:    push_rx(dir_rows[i].rx, 1'b0, '0);
      endcase
    end

    // Random frames in four register settings: random, all zero, all ones,
    // random. The extreme settings open with a full-size payload.
    for (int p = 0; p < 4; p++) begin
      case (p)
        1:       c = '0;
        2:       c = '1;
        default: c = adf_pkg::cfg_t'($urandom());
      endcase
      set_registers(c);
      // all-zero setting: hold the sink off and send without gaps so the
      // ring and queue fill and rx backs up; keep sending until released
      if (p == 1) begin
        source_calm = HOLD_CALM;
        hold_go = 1'b1;
      end
      frame_items = 0;
      first = 1'b1;
      while (frame_items < PHASE_ITEMS || (hold_go && !long_hold_done)) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 3)) push_rx(rand_byte(), 1'b0, '0);
        end
        r = $urandom_range(0, 19);
        if (first && (p == 1 || p == 2)) plen = MAX_CORE;
        else if (r < 14) plen = $urandom_range(0, 4);
        else if (r < 19) plen = $urandom_range(5, 20);
        else plen = MAX_CORE;
        r = $urandom_range(0, 9);
        if (first || r < 7) flaw = FLAW_NONE;
        else if (r == 7) flaw = FLAW_BYTE;
        else if (r == 8) flaw = FLAW_LENGTH;
        else flaw = FLAW_CUT;
        send_frame(plen, flaw);
        first = 1'b0;
      end
    end

    // Stop offering, let the last bursts drain, then look for stragglers.
    rx_if.valid <= 1'b0;
    while (payload_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/adf_pkg.sv
rtl/adf_if.sv
rtl/adf_front.sv
rtl/adf_desc_fifo.sv
rtl/adf_back.sv
rtl/addressed_frame_deframer_core.sv
tb/addressed_frame_deframer_core_tb.sv
